/* rtl/core/tt_pkg.sv */
// ----------------------------------------------------------------------------
// tt_pkg: shared types and constants of the transposition table
// Request and result structs, table geometry, and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package tt_pkg;

	// Table geometry (power of two, so the index is the low key bits)
	localparam int TABLE_ENTRIES = 4096;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int KEY_W         = 64;

	// Request codes
	localparam logic CMD_STORE    = 1'b0;
	localparam logic CMD_RETRIEVE = 1'b1;

	// Bound kinds
	localparam logic [1:0] KIND_EXACT = 2'd0;
	localparam logic [1:0] KIND_LOWER = 2'd1;
	localparam logic [1:0] KIND_UPPER = 2'd2;

	// Square code reported on a miss
	localparam logic [6:0] MISS_SQUARE = 7'd64;

	// Request payload
	typedef struct packed {
		logic               cmd;
		logic [KEY_W-1:0]   pos_key;
		logic [7:0]         search_depth;
		logic [1:0]         bound_kind;
		logic [5:0]         move_from;
		logic [5:0]         move_to;
		logic signed [15:0] move_score;
		logic               side;
		logic signed [15:0] alpha_bound;
		logic signed [15:0] beta_bound;
	} tt_req_t;

	// Result payload
	typedef struct packed {
		logic               hit;
		logic [6:0]         best_from;
		logic [6:0]         best_to;
		logic signed [15:0] best_score;
	} tt_rsp_t;

	// Controller state
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WRITE,
		ST_READ,
		ST_MATCH
	} tt_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic latch_req;
		logic clr_we;
		logic wr_en;
		logic rd_en;
		logic load_rsp;
	} tt_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic clr_last;
	} tt_status_t;

endpackage

/* rtl/core/tt_ram.sv */
// ----------------------------------------------------------------------------
// tt_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/tt_ctrl.sv */
// ----------------------------------------------------------------------------
// tt_ctrl: transposition table controller
// Sequences the clearing pass, stores and retrieves; drives busy and done.
// ----------------------------------------------------------------------------
module tt_ctrl
	import tt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       req_cmd,
	input  tt_status_t status,
	output tt_cmd_t    cmd,
	output logic       busy,
	output logic       done
);

	tt_state_t state_q;
	tt_state_t state_d;
	logic      done_q;

	// State register and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_MATCH);
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_we = 1'b1;
				if (status.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.latch_req = 1'b1;
					state_d = (req_cmd == CMD_STORE) ? ST_WRITE : ST_READ;
				end
			end
			ST_WRITE: begin
				cmd.wr_en = 1'b1;
				state_d   = ST_IDLE;
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_MATCH;
			end
			ST_MATCH: begin
				cmd.load_rsp = 1'b1;
				state_d      = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	assign done = done_q;

endmodule

/* rtl/core/tt_datapath.sv */
// ----------------------------------------------------------------------------
// tt_datapath: transposition table datapath
// Request register, clear address counter, entry RAM and hit evaluation.
// ----------------------------------------------------------------------------
module tt_datapath
	import tt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  tt_req_t    req,
	input  tt_cmd_t    cmd,
	output tt_status_t status,
	output tt_rsp_t    rsp
);

	// Stored entry info, scores kept from white's view
	typedef struct packed {
		logic [7:0]         depth;
		logic [1:0]         kind;
		logic [5:0]         from_sq;
		logic [5:0]         to_sq;
		logic signed [15:0] score;
		logic               side;
	} tt_info_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		tt_info_t         info;
	} tt_entry_t;

	localparam int ENTRY_W = $bits(tt_entry_t);

	// Negation that saturates the most negative score
	function automatic logic signed [15:0] neg_sat(input logic signed [15:0] s);
		logic signed [15:0] r;
		if (s == 16'sh8000) begin
			r = 16'sh7FFF;
		end else begin
			r = -s;
		end
		return r;
	endfunction

	// Lower and upper bound kinds trade places
	function automatic logic [1:0] swap_kind(input logic [1:0] k);
		logic [1:0] r;
		r = k;
		if (k == KIND_LOWER) begin
			r = KIND_UPPER;
		end else if (k == KIND_UPPER) begin
			r = KIND_LOWER;
		end
		return r;
	endfunction

	tt_req_t          req_q;
	logic [IDX_W-1:0] clr_addr_q;
	tt_rsp_t          rsp_q;

	logic [IDX_W-1:0]   req_idx;
	tt_entry_t          clear_entry;
	tt_entry_t          store_entry;
	tt_entry_t          wr_entry;
	tt_entry_t          rd_entry;
	logic [ENTRY_W-1:0] rd_data;
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;

	logic signed [15:0] look_score;
	logic [1:0]         look_kind;
	logic               look_match;
	logic               look_usable;
	logic               look_hit;

	// Request register
	always_ff @(posedge clk) begin
		if (cmd.latch_req) begin
			req_q <= req;
		end
	end

	// Clearing pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_we) begin
			clr_addr_q <= clr_addr_q + IDX_W'(1);
		end
	end

	assign status.clr_last = (clr_addr_q == IDX_W'(TABLE_ENTRIES - 1));
	assign req_idx         = req_q.pos_key[IDX_W-1:0];

	// Cleared entry: key one at entry 0 so key zero never matches
	always_comb begin
		clear_entry      = '0;
		clear_entry.key  = (clr_addr_q == '0) ? KEY_W'(1) : '0;
	end

	// Entry to store, converted to white's view
	always_comb begin
		store_entry.key          = req_q.pos_key;
		store_entry.info.depth   = req_q.search_depth;
		store_entry.info.from_sq = req_q.move_from;
		store_entry.info.to_sq   = req_q.move_to;
		store_entry.info.side    = req_q.side;
		if (req_q.side) begin
			store_entry.info.score = neg_sat(req_q.move_score);
			store_entry.info.kind  = swap_kind(req_q.bound_kind);
		end else begin
			store_entry.info.score = req_q.move_score;
			store_entry.info.kind  = req_q.bound_kind;
		end
	end

	// Write port select
	assign ram_we    = cmd.clr_we | cmd.wr_en;
	assign ram_waddr = cmd.clr_we ? clr_addr_q : req_idx;
	assign wr_entry  = cmd.clr_we ? clear_entry : store_entry;

	tt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_entry),
		.re    (cmd.rd_en),
		.raddr (req_idx),
		.rdata (rd_data)
	);

	assign rd_entry = tt_entry_t'(rd_data);

	// Lookup evaluation from the requesting side's view
	always_comb begin
		if (req_q.side) begin
			look_score = neg_sat(rd_entry.info.score);
			look_kind  = swap_kind(rd_entry.info.kind);
		end else begin
			look_score = rd_entry.info.score;
			look_kind  = rd_entry.info.kind;
		end
		look_match  = (rd_entry.info.side == req_q.side) &&
		              (rd_entry.key == req_q.pos_key) &&
		              (rd_entry.info.depth >= req_q.search_depth);
		look_usable = (look_kind == KIND_EXACT) ||
		              ((look_kind == KIND_LOWER) && (look_score >= req_q.beta_bound)) ||
		              ((look_kind == KIND_UPPER) && (look_score <= req_q.alpha_bound));
		look_hit    = look_match && look_usable;
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.load_rsp) begin
			rsp_q.hit <= look_hit;
			if (look_hit) begin
				rsp_q.best_from  <= {1'b0, rd_entry.info.from_sq};
				rsp_q.best_to    <= {1'b0, rd_entry.info.to_sq};
				rsp_q.best_score <= look_score;
			end else begin
				rsp_q.best_from  <= MISS_SQUARE;
				rsp_q.best_to    <= MISS_SQUARE;
				rsp_q.best_score <= '0;
			end
		end
	end

	assign rsp = rsp_q;

endmodule

/* rtl/core/transposition_table.sv */
// ----------------------------------------------------------------------------
// transposition_table: direct-mapped, always-replace position cache
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high and busy low.
//   req.cmd selects store or retrieve; the entry index is the low key bits.
//   A store writes the entry and gives no result; it keeps busy high for
//   one cycle after acceptance, while the entry is written.
//   A retrieve reads the entry and reports hit, best move and score. done
//   is high for exactly one cycle with rsp, after the READ and MATCH states;
//   the next request may be taken in that same cycle.
//   A new request is taken only once the previous one is through; a retrieve
//   waits on the registered read port of the single entry RAM.
//   Results cannot be held off; the receiver must take rsp while done is high.
//   After reset the block runs a clearing pass over all 4096 table entries,
//   one entry a cycle, with busy high; entry 0 gets key one.
// ----------------------------------------------------------------------------
module transposition_table
	import tt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  tt_req_t req,
	output logic    done,
	output tt_rsp_t rsp
);

	tt_cmd_t    cmd;
	tt_status_t status;

	// Control sequencing
	tt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req_cmd (req.cmd),
		.status  (status),
		.cmd     (cmd),
		.busy    (busy),
		.done    (done)
	);

	// Storage and evaluation
	tt_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.status (status),
		.rsp    (rsp)
	);

endmodule

/* rtl/core/tt_checker.sv */
// ----------------------------------------------------------------------------
// tt_checker: port-level checks for the transposition table
// Request/result timing and miss encoding, bound to the top level.
// ----------------------------------------------------------------------------
module tt_checker
	import tt_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input tt_req_t req,
	input logic    done,
	input tt_rsp_t rsp
);

	// An accepted retrieve is answered with done
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.cmd == CMD_RETRIEVE) |=> ##2 done)
		else $error("retrieve result missing");

	// A store produces no result
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.cmd == CMD_STORE) |=> !done ##1 !done ##1 !done ##1 !done)
		else $error("store produced a result");

	// An accepted request makes the block busy
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("not busy after accepting a request");

	// A miss reports the fixed miss move and score
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.hit) |-> (rsp.best_from == MISS_SQUARE &&
		rsp.best_to == MISS_SQUARE && rsp.best_score == 16'sd0))
		else $error("miss result malformed");

	// Results are shown only while idle
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

endmodule

bind transposition_table tt_checker u_tt_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.req    (req),
	.done   (done),
	.rsp    (rsp)
);
